### sv/mono_framebuffer_raster_engine_macros.svh
// Assertion macros shared by the checker of the raster engine.
`ifndef MONO_FRAMEBUFFER_RASTER_ENGINE_MACROS_SVH
`define MONO_FRAMEBUFFER_RASTER_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MFBRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MFBRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mfbre_pkg.sv
// Shared constants, codes, types and the pixel operation function of the raster engine.
package mfbre_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  localparam logic [2:0] FUNC_PIXEL = 3'd0;
  localparam logic [2:0] FUNC_HRUN  = 3'd1;
  localparam logic [2:0] FUNC_VRUN  = 3'd2;
  localparam logic [2:0] FUNC_CLEAR = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;

  localparam logic [7:0] FULL_MASK = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef struct packed {
    logic load;
    logic clip;
    logic plan;
    logic mem_rd;
    logic mem_wr;
    logic clr_wr;
    logic idx_rd;
    logic take_read;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       clip_empty;
    logic       walk_last;
    logic       clr_last;
  } status_t;

  function automatic logic [7:0] apply_op(input logic [7:0] data,
                                          input logic [7:0] mask,
                                          input logic [1:0] op);
    logic [7:0] res;
    unique case (op)
      OP_CLEAR:  res = data & ~mask;
      OP_SET:    res = data | mask;
      OP_TOGGLE: res = data ^ mask;
      default:   res = data;
    endcase
    return res;
  endfunction

endpackage

### sv/mfbre_ctrl.sv
// Command sequencer of the raster engine.
module mfbre_ctrl import mfbre_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  output cmd_t    cmd,
  input  status_t sts
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLIP  = 4'd2;
  localparam logic [3:0] S_PLAN  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_CLEAR = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_RWAIT = 4'd8;

  logic [3:0] state, state_next;
  logic       done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CLIP;
        end
      end
      S_CLIP: begin
        cmd.clip = 1'b1;
        unique case (sts.func) inside
          FUNC_PIXEL, FUNC_HRUN, FUNC_VRUN: state_next = S_PLAN;
          FUNC_CLEAR: state_next = S_CLEAR;
          FUNC_READ:  state_next = S_READ;
          default: begin
            state_next = S_IDLE;
            done_next  = 1'b1;
          end
        endcase
      end
      S_PLAN: begin
        if (sts.clip_empty) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          cmd.plan   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        if (sts.walk_last) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          state_next = S_RD;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_READ: begin
        cmd.idx_rd = 1'b1;
        state_next = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.take_read = 1'b1;
        state_next    = S_IDLE;
        done_next     = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

### sv/mfbre_dpath.sv
// Clipping, address walk and frame store of the raster engine.
module mfbre_dpath import mfbre_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic [2:0]         func,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic signed [15:0] run_length,
  input  logic [1:0]         color_op,
  input  logic [9:0]         byte_index,
  output logic [7:0]         read_data,
  output logic               clipped_away
);

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PG_W        = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int MAX_WH      = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int LIM_W       = $clog2(MAX_WH + 1);
  localparam int MAX_CNT     = (SCREEN_WIDTH > PAGES) ? SCREEN_WIDTH : PAGES;
  localparam int CNT_W       = $clog2(MAX_CNT + 1);

  // Latched command
  logic [2:0]         func_r;
  logic signed [15:0] x_r, y_r, len_r;
  logic [1:0]         op_r;
  logic [9:0]         idx_r;

  // Clip results
  logic [LIM_W-1:0] lo_r, hi_r, c_r;
  logic             vert_r, empty_r;

  // Walk state
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              first_r;
  logic [7:0]        mask_first_r, mask_last_r, mask_mid_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        mem_q;

  // Clip stage
  logic               is_vert, is_draw;
  logic signed [15:0] s16, c16, len16;
  logic signed [16:0] a17, b17, lo17, hi17, c17, lim_s17, lim_c17;
  logic               empty;

  always_comb begin
    is_vert = (func_r == FUNC_VRUN);
    is_draw = (func_r == FUNC_PIXEL) || (func_r == FUNC_HRUN) || (func_r == FUNC_VRUN);
    s16     = is_vert ? y_r : x_r;
    c16     = is_vert ? x_r : y_r;
    len16   = (func_r == FUNC_PIXEL) ? 16'sd1 : len_r;
    lim_s17 = is_vert ? 17'(SCREEN_HEIGHT) : 17'(SCREEN_WIDTH);
    lim_c17 = is_vert ? 17'(SCREEN_WIDTH) : 17'(SCREEN_HEIGHT);
    a17     = {s16[15], s16};
    c17     = {c16[15], c16};
    b17     = a17 + {len16[15], len16};
    lo17    = (a17 < 17'sd0) ? 17'sd0 : a17;
    hi17    = (b17 > lim_s17) ? lim_s17 : b17;
    empty   = (hi17 <= lo17) || (c17 < 17'sd0) || (c17 >= lim_c17);
  end

  // Plan stage
  logic [LIM_W-1:0]  hm1;
  logic [PG_W-1:0]   row_page, lo_page, last_page;
  logic [ADDR_W-1:0] plan_addr;
  logic [CNT_W-1:0]  plan_cnt;
  logic [7:0]        row_mask;

  always_comb begin
    hm1       = hi_r - LIM_W'(1);
    row_page  = PG_W'(c_r >> 3);
    lo_page   = PG_W'(lo_r >> 3);
    last_page = PG_W'(hm1 >> 3);
    row_mask  = 8'd1 << c_r[2:0];
    if (vert_r) begin
      plan_addr = ADDR_W'(lo_page * SCREEN_WIDTH + c_r);
      plan_cnt  = CNT_W'(last_page - lo_page) + CNT_W'(1);
    end else begin
      plan_addr = ADDR_W'(row_page * SCREEN_WIDTH + lo_r);
      plan_cnt  = CNT_W'(hi_r - lo_r);
    end
  end

  // Walk
  logic              walk_last;
  logic [7:0]        cur_mask;
  logic [ADDR_W-1:0] step;
  logic              clr_last;
  logic              idx_ok;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata;

  always_comb begin
    walk_last = (cnt_r == CNT_W'(1));
    cur_mask  = mask_mid_r & (first_r ? mask_first_r : FULL_MASK)
                & (walk_last ? mask_last_r : FULL_MASK);
    step      = vert_r ? ADDR_W'(SCREEN_WIDTH) : ADDR_W'(1);
    clr_last  = (clr_addr_r == ADDR_W'(STORE_BYTES - 1));
    idx_ok    = (32'(idx_r) < STORE_BYTES);
    mem_we    = cmd.mem_wr || cmd.clr_wr;
    mem_re    = cmd.mem_rd || cmd.idx_rd;
    waddr     = cmd.clr_wr ? clr_addr_r : addr_r;
    wdata     = cmd.clr_wr ? ZERO_BYTE : apply_op(mem_q, cur_mask, op_r);
    raddr     = cmd.idx_rd ? ADDR_W'(idx_r) : addr_r;
  end

  // Hold the read byte until the write or the readback takes it
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r       <= func;
      x_r          <= x_coord;
      y_r          <= y_coord;
      len_r        <= run_length;
      op_r         <= color_op;
      idx_r        <= byte_index;
      read_data    <= ZERO_BYTE;
      clipped_away <= 1'b0;
    end
    if (cmd.clip) begin
      lo_r         <= LIM_W'(lo17);
      hi_r         <= LIM_W'(hi17);
      c_r          <= LIM_W'(c17);
      vert_r       <= is_vert;
      empty_r      <= empty;
      clipped_away <= is_draw && empty;
    end
    if (cmd.plan) begin
      addr_r       <= plan_addr;
      cnt_r        <= plan_cnt;
      first_r      <= 1'b1;
      mask_mid_r   <= vert_r ? FULL_MASK : row_mask;
      mask_first_r <= vert_r ? (FULL_MASK << lo_r[2:0]) : row_mask;
      mask_last_r  <= vert_r ? (FULL_MASK >> (3'd7 - hm1[2:0])) : row_mask;
    end
    if (cmd.mem_wr) begin
      addr_r  <= addr_r + step;
      cnt_r   <= cnt_r - CNT_W'(1);
      first_r <= 1'b0;
    end
    if (cmd.take_read) begin
      read_data <= idx_ok ? mem_q : ZERO_BYTE;
    end
  end

  // Sweep pointer wraps to zero after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + ADDR_W'(1);
    end
  end

  assign sts.func       = func_r;
  assign sts.clip_empty = empty_r;
  assign sts.walk_last  = walk_last;
  assign sts.clr_last   = clr_last;

endmodule

### sv/mono_framebuffer_raster_engine.sv
// Top level of the monochrome frame store raster engine.
// A command is taken when start is high and busy is low; its one result shows on read_data and
// clipped_away for the single cycle in which done is high, and the receiver cannot hold it off.
// A new command may be started in that same cycle. The frame store is one byte-wide memory with
// one read and one write port. A draw is latched, clipped and planned, then reads and rewrites
// each byte it touches (one per column of a horizontal run, one per page of a vertical run) in
// a read state and a write state. A draw that clips away entirely ends after the plan state, a
// byte read reads the store and then returns the byte, an unused code ends after the clip state.
// Clear all zeroes one byte a cycle; reset sweeps the store to zero the same way, with busy high.
module mono_framebuffer_raster_engine import mfbre_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [2:0]         func,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic signed [15:0] run_length,
  input  logic [1:0]         color_op,
  input  logic [9:0]         byte_index,
  output logic [7:0]         read_data,
  output logic               clipped_away
);

  cmd_t    cmd;
  status_t sts;

  mfbre_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  mfbre_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .run_length   (run_length),
    .color_op     (color_op),
    .byte_index   (byte_index),
    .read_data    (read_data),
    .clipped_away (clipped_away)
  );

endmodule

### sv/mfbre_checker.sv
// Port-level checks of the raster engine and their binding to the top level.
`include "mono_framebuffer_raster_engine_macros.svh"

module mfbre_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] read_data,
  input logic       clipped_away
);

  `MFBRE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `MFBRE_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
  `MFBRE_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `MFBRE_ASSERT_IMP(a_clip_no_data, done && clipped_away, read_data == 8'h00,
                    "clipped draw returned read data")

endmodule

bind mono_framebuffer_raster_engine mfbre_checker u_checker (.*);
